[src/vfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types, request codes, command opcodes and the font table for the
// VFD command serializer.
// ----------------------------------------------------------------------------
package vfd_pkg;

	// request kinds
	localparam logic [2:0] FN_CHAR   = 3'd0;
	localparam logic [2:0] FN_BRIGHT = 3'd1;
	localparam logic [2:0] FN_DIGITS = 3'd2;
	localparam logic [2:0] FN_LIGHT  = 3'd3;
	localparam logic [2:0] FN_PORTS  = 3'd4;

	// command opcodes (high nibble)
	localparam logic [3:0] OP_RAM_WRITE = 4'h1;
	localparam logic [3:0] OP_PORTS     = 4'h4;
	localparam logic [3:0] OP_BRIGHT    = 4'h5;
	localparam logic [3:0] OP_DIGITS    = 4'h6;
	localparam logic [3:0] OP_LIGHT     = 4'h7;

	// command queue geometry
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// one queued item: one or two command bytes, low byte goes out first
	typedef struct packed {
		logic [15:0] word;
		logic        two;
		logic        close;
	} vfd_entry_t;

	// character code to display glyph code
	function automatic logic [7:0] font_rom(input logic [7:0] c);
		logic [7:0] r;
		case (c) inside
			8'h00:        r = 8'h2e;
			8'h01:        r = 8'h8f;
			8'h02:        r = 8'he4;
			8'h03:        r = 8'hdd;
			8'h04:        r = 8'hdc;
			8'h80:        r = 8'h84;
			8'h81:        r = 8'h94;
			8'h82:        r = 8'h81;
			8'h83:        r = 8'h8e;
			8'h84:        r = 8'h99;
			8'h85:        r = 8'h9a;
			8'h86:        r = 8'hb1;
			8'hfe, 8'hff: r = 8'h00;
			default: begin
				// printable ranges pass through, the rest shows a blank
				if ((c >= 8'h10 && c < 8'h1d) || (c >= 8'h20 && c < 8'h80))
					r = c;
				else
					r = 8'h10;
			end
		endcase
		return r;
	endfunction

endpackage

[src/vfd_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_req_if
// Request channel: one display request per item.
// ----------------------------------------------------------------------------
interface vfd_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        func;
	logic [3:0]        address;
	logic [7:0]        char_code;
	logic              last_char;
	logic signed [7:0] value;
	logic              port_a;
	logic              port_b;

	modport source (
		output valid, func, address, char_code, last_char, value, port_a, port_b,
		input  ready
	);
	modport sink (
		input  valid, func, address, char_code, last_char, value, port_a, port_b,
		output ready
	);
endinterface

[src/vfd_bit_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_bit_if
// Serial bit channel: one command bit per item.
// ----------------------------------------------------------------------------
interface vfd_bit_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic frame_end;
	logic last;

	modport source (
		output valid, data_bit, frame_end, last,
		input  ready
	);
	modport sink (
		input  valid, data_bit, frame_end, last,
		output ready
	);
endinterface

[src/vfd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_queue
// Small register queue of encoded command items between decoder and shifter.
// ----------------------------------------------------------------------------
module vfd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vfd_pkg::vfd_entry_t push_data,
	input  logic                pop,
	output vfd_pkg::vfd_entry_t pop_data,
	output logic                full,
	output logic                empty
);

	vfd_pkg::vfd_entry_t             mem_q [vfd_pkg::Q_DEPTH];
	logic [vfd_pkg::Q_AW-1:0]        wr_ptr_q;
	logic [vfd_pkg::Q_AW-1:0]        rd_ptr_q;
	logic [vfd_pkg::Q_CW-1:0]        count_q;

	localparam logic [vfd_pkg::Q_AW-1:0] PTR_LAST = vfd_pkg::Q_AW'(vfd_pkg::Q_DEPTH - 1);
	localparam logic [vfd_pkg::Q_CW-1:0] CNT_FULL = vfd_pkg::Q_CW'(vfd_pkg::Q_DEPTH);

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[src/vfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_front
// Accepts requests, clamps operands, builds command bytes and tracks bursts.
// ----------------------------------------------------------------------------
module vfd_front (
	input  logic                clk,
	input  logic                arst_n,
	vfd_req_if.sink             req,
	input  logic                q_full,
	output logic                q_push,
	output vfd_pkg::vfd_entry_t q_data
);

	logic                burst_open_q;
	logic                accept;
	logic                known;
	logic [7:0]          glyph;
	logic [3:0]          operand;
	vfd_pkg::vfd_entry_t ent;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign glyph     = vfd_pkg::font_rom(req.char_code);

	// operand clamping per request kind
	always_comb begin
		operand = '0;
		case (req.func)
			vfd_pkg::FN_BRIGHT: begin
				if (req.value < 0)
					operand = 4'd0;
				else if (req.value > 8'sd7)
					operand = 4'd7;
				else
					operand = {1'b0, req.value[2:0]};
			end
			vfd_pkg::FN_DIGITS: begin
				// below 9 maps to 1, 9..15 to 1..7, 16 and above to 0
				if (req.value < 8'sd9)
					operand = 4'd1;
				else if (req.value > 8'sd15)
					operand = 4'd0;
				else
					operand = {1'b0, req.value[2:0]};
			end
			vfd_pkg::FN_LIGHT: begin
				if (req.value < 0 || req.value > 8'sd3)
					operand = 4'd3;
				else
					operand = {2'b00, req.value[1:0]};
			end
			vfd_pkg::FN_PORTS: operand = {2'b00, req.port_b, req.port_a};
			default:           operand = '0;
		endcase
	end

	// command encoder
	always_comb begin
		known = 1'b1;
		ent   = '0;
		unique case (req.func)
			vfd_pkg::FN_CHAR: begin
				if (!burst_open_q) begin
					ent.word = {glyph, vfd_pkg::OP_RAM_WRITE, req.address};
					ent.two  = 1'b1;
				end else begin
					ent.word = {8'h00, glyph};
					ent.two  = 1'b0;
				end
				ent.close = req.last_char;
			end
			vfd_pkg::FN_BRIGHT: begin
				ent.word  = {8'h00, vfd_pkg::OP_BRIGHT, operand};
				ent.close = 1'b1;
			end
			vfd_pkg::FN_DIGITS: begin
				ent.word  = {8'h00, vfd_pkg::OP_DIGITS, operand};
				ent.close = 1'b1;
			end
			vfd_pkg::FN_LIGHT: begin
				ent.word  = {8'h00, vfd_pkg::OP_LIGHT, operand};
				ent.close = 1'b1;
			end
			vfd_pkg::FN_PORTS: begin
				ent.word  = {8'h00, vfd_pkg::OP_PORTS, operand};
				ent.close = 1'b1;
			end
			default: known = 1'b0;
		endcase
	end

	assign q_push = accept && known;
	assign q_data = ent;

	// burst tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_open_q <= 1'b0;
		end else if (q_push) begin
			burst_open_q <= !ent.close;
		end
	end

endmodule

[src/vfd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_back
// Shifts queued command bytes out one bit per item, least significant first.
// ----------------------------------------------------------------------------
module vfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  vfd_pkg::vfd_entry_t q_data,
	output logic                q_pop,
	vfd_bit_if.source           bits
);

	logic [15:0] sh_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        close_q;
	logic        fin;
	logic        done;

	assign fin     = (cnt_q == '0);
	assign done    = bits.valid && bits.ready && fin;
	assign q_pop   = (!busy_q || done) && !q_empty;

	assign bits.valid     = busy_q;
	assign bits.data_bit  = sh_q[0];
	assign bits.last      = fin;
	assign bits.frame_end = fin && close_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			cnt_q  <= q_data.two ? 4'd15 : 4'd7;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (bits.valid && bits.ready) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sh_q    <= q_data.word;
			close_q <= q_data.close;
		end else if (bits.valid && bits.ready) begin
			sh_q <= {1'b0, sh_q[15:1]};
		end
	end

endmodule

[src/vfd_command_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_command_serializer
// Display requests in, serial command bits for a VFD controller out.
// ----------------------------------------------------------------------------
// Each accepted request produces 8 serial bits, or 16 for the first character
// of a burst (address command then glyph), one bit per clock while the sink is
// ready; the bit shifter sets the rate. Unused request kinds produce no bits.
// A two-entry command queue lets new requests be taken while bits are still
// being shifted; a queued item loads in the same cycle the last bit goes out.
module vfd_command_serializer (
	input  logic      clk,
	input  logic      arst_n,
	vfd_req_if.sink   req,
	vfd_bit_if.source bits
);

	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	vfd_pkg::vfd_entry_t q_wdata;
	vfd_pkg::vfd_entry_t q_rdata;

	// request decoder
	vfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// command queue
	vfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	// bit shifter
	vfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.bits    (bits)
	);

`ifndef NO_ASSERTIONS
	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// no read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

	// chip select only released on the final bit of an item
	a_frame_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(bits.valid && bits.frame_end) |-> bits.last)
		else $error("frame end away from item end");
`endif

endmodule
